/* sv/spq_pkg.sv */
// Shared types and constants for the stable priority packet queue.
// Depends on nothing; spq_seq and the top level import it.
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OUT_ENQ_OK   = 3'd0,
    OUT_ENQ_FULL = 3'd1,
    OUT_DEQ_OK   = 3'd2,
    OUT_PEEK_OK  = 3'd3,
    OUT_EMPTY    = 3'd4,
    OUT_CLEAR    = 3'd5
  } outcome_e;

  // One queue entry as it is stored in the slot memory.
  typedef struct packed {
    logic [31:0] arrival;
    logic [7:0]  pri;
    logic [15:0] id;
    logic [15:0] size;
    logic [7:0]  src;
    logic [7:0]  dst;
  } slot_t;

  // Completion report from the sequencer to the statistics stage.
  typedef struct packed {
    logic             fire;
    outcome_e         outcome;
    slot_t            head;
    logic [31:0]      wait_ticks;
    logic [CNT_W-1:0] count;
  } done_t;

endpackage

`default_nettype wire

/* sv/spq_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module spq_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* sv/spq_seq.sv */
// Request sequencer: keeps the slot memory sorted by shifting entries one per cycle.
// Depends on spq_pkg and spq_ram.
`default_nettype none

module spq_seq (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [1:0]               req_type_i,
  input  wire logic [15:0]              packet_id_i,
  input  wire logic [7:0]               priority_req_i,
  input  wire logic [15:0]              size_units_i,
  input  wire logic [7:0]               source_node_i,
  input  wire logic [7:0]               dest_node_i,
  input  wire logic [31:0]              time_now_i,
  input  wire logic [spq_pkg::CNT_W-1:0] limit_i,
  output spq_pkg::done_t                done_o
);

  import spq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INS       = 7'b0000010,
    S_INS_LAST  = 7'b0000100,
    S_DEQ_HEAD  = 7'b0001000,
    S_DEQ_SHIFT = 7'b0010000,
    S_PEEK      = 7'b0100000,
    S_FIN       = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] bound;
  outcome_e         out_q, out_d;
  slot_t            new_q, new_d;
  slot_t            head_q, head_d;
  logic [31:0]      wait_q, wait_d;
  slot_t            in_slot;
  slot_t            rdata;
  logic [$bits(slot_t)-1:0] rdata_raw;
  logic             we;
  logic [IDX_W-1:0] wr_addr;
  slot_t            wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic             full;

  spq_ram #(
    .DATA_W($bits(slot_t)),
    .DEPTH (QUEUE_DEPTH),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .raddr_i(rd_addr),
    .rdata_o(rdata_raw)
  );

  assign rdata = slot_t'(rdata_raw);

  assign in_slot = '{arrival: time_now_i, pri: priority_req_i, id: packet_id_i,
                     size: size_units_i, src: source_node_i, dst: dest_node_i};

  assign bound = (limit_i < CNT_W'(QUEUE_DEPTH)) ? limit_i : CNT_W'(QUEUE_DEPTH);
  assign full  = (cnt_q >= bound);
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    out_d   = out_q;
    new_d   = new_q;
    head_d  = head_q;
    wait_d  = wait_q;
    we      = 1'b0;
    wr_addr = idx_q;
    wr_data = new_q;
    rd_addr = idx_q + IDX_W'(1);
    done_o  = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i && (req_e'(req_type_i) == REQ_ENQ)) begin
          rd_addr = cnt_q[IDX_W-1:0] - IDX_W'(1);
        end else begin
          rd_addr = '0;
        end
        if (start_i) begin
          new_d = in_slot;
          case (req_e'(req_type_i))
            REQ_ENQ: begin
              if (full) begin
                out_d   = OUT_ENQ_FULL;
                state_d = S_FIN;
              end else if (cnt_q == '0) begin
                we      = 1'b1;
                wr_addr = '0;
                wr_data = in_slot;
                out_d   = OUT_ENQ_OK;
                state_d = S_FIN;
              end else begin
                idx_d   = cnt_q[IDX_W-1:0];
                out_d   = OUT_ENQ_OK;
                state_d = S_INS;
              end
            end
            REQ_DEQ: begin
              if (cnt_q == '0) begin
                out_d   = OUT_EMPTY;
                state_d = S_FIN;
              end else begin
                out_d   = OUT_DEQ_OK;
                state_d = S_DEQ_HEAD;
              end
            end
            REQ_PEEK: begin
              if (cnt_q == '0) begin
                out_d   = OUT_EMPTY;
                state_d = S_FIN;
              end else begin
                out_d   = OUT_PEEK_OK;
                state_d = S_PEEK;
              end
            end
            default: begin
              out_d   = OUT_CLEAR;
              state_d = S_FIN;
            end
          endcase
        end
      end

      // The entry just below the write slot is in rdata. An equal or higher
      // priority stops the walk so that equal priorities keep arrival order.
      S_INS: begin
        rd_addr = idx_q - IDX_W'(2);
        we      = 1'b1;
        wr_addr = idx_q;
        if (rdata.pri >= new_q.pri) begin
          wr_data = new_q;
          state_d = S_FIN;
        end else begin
          wr_data = rdata;
          if (idx_q == IDX_W'(1)) begin
            state_d = S_INS_LAST;
          end else begin
            idx_d = idx_q - IDX_W'(1);
          end
        end
      end

      S_INS_LAST: begin
        we      = 1'b1;
        wr_addr = '0;
        wr_data = new_q;
        state_d = S_FIN;
      end

      S_DEQ_HEAD: begin
        head_d  = rdata;
        wait_d  = new_q.arrival - rdata.arrival;
        idx_d   = IDX_W'(1);
        rd_addr = IDX_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_DEQ_SHIFT;
        end
      end

      // Entry idx_q is in rdata and moves down by one slot.
      S_DEQ_SHIFT: begin
        we      = 1'b1;
        wr_addr = idx_q - IDX_W'(1);
        wr_data = rdata;
        if (CNT_W'(idx_q) == cnt_q - CNT_W'(1)) begin
          state_d = S_FIN;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_PEEK: begin
        head_d  = rdata;
        state_d = S_FIN;
      end

      S_FIN: begin
        case (out_q)
          OUT_ENQ_OK: cnt_d = cnt_q + CNT_W'(1);
          OUT_DEQ_OK: cnt_d = cnt_q - CNT_W'(1);
          OUT_CLEAR:  cnt_d = '0;
          default:    cnt_d = cnt_q;
        endcase
        done_o.fire       = 1'b1;
        done_o.outcome    = out_q;
        done_o.head       = head_q;
        done_o.wait_ticks = wait_q;
        done_o.count      = cnt_d;
        state_d           = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      out_q   <= OUT_CLEAR;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      out_q   <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q  <= new_d;
    head_q <= head_d;
    wait_q <= wait_d;
  end

endmodule

`default_nettype wire

/* sv/stable_priority_packet_queue.sv */
// Top level of the stable priority packet queue: limit register, statistics, result words.
// Depends on spq_pkg and spq_seq.
//
// A request word is taken at a rising edge with start high and busy low.
// req_type_i selects enqueue, dequeue, peek or clear; the packet fields and
// time_now_i come with it. Exactly one result word follows, shown for one
// cycle with done_o high; the receiver cannot stall, so it must take it then.
// Packets sit sorted in one slot memory with a registered read port, and
// reordering moves one entry per cycle through that memory's ports.
// An enqueue takes longer the more stored packets have lower priority, and
// a dequeue the more packets are stored. busy falls in the same cycle that
// done_o rises, so the next request is taken at the earliest at the edge
// that ends the result cycle.
// The occupancy limit is written over the cfg_valid_i / cfg_ready_o channel,
// which is always ready; write it only while the block is idle.
// Reset empties the queue, zeroes the statistics and sets the limit to 64.
`default_nettype none

module stable_priority_packet_queue (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                req_type_i,
  input  wire logic [15:0]               packet_id_i,
  input  wire logic [7:0]                priority_req_i,
  input  wire logic [15:0]               size_units_i,
  input  wire logic [7:0]                source_node_i,
  input  wire logic [7:0]                dest_node_i,
  input  wire logic [31:0]               time_now_i,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [spq_pkg::CNT_W-1:0] cfg_data_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [15:0]                    out_id_o,
  output logic [7:0]                     out_priority_o,
  output logic [15:0]                    out_size_o,
  output logic [7:0]                     out_source_o,
  output logic [7:0]                     out_dest_o,
  output logic [31:0]                    wait_ticks_o,
  output logic [spq_pkg::CNT_W-1:0]      occupancy_o,
  output logic [31:0]                    offered_count_o,
  output logic [31:0]                    served_count_o,
  output logic [31:0]                    dropped_count_o,
  output logic [47:0]                    wait_total_o
);

  import spq_pkg::*;

  done_t            done;
  logic [CNT_W-1:0] limit_q;
  logic             done_q;
  logic [31:0]      offered_q, offered_d;
  logic [31:0]      served_q, served_d;
  logic [31:0]      dropped_q, dropped_d;
  logic [47:0]      wsum_q, wsum_d;
  logic [CNT_W-1:0] occ_q;
  status_e          status_q, status_d;
  slot_t            head_q, head_d;
  logic [31:0]      wait_q, wait_d;

  spq_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .req_type_i    (req_type_i),
    .packet_id_i   (packet_id_i),
    .priority_req_i(priority_req_i),
    .size_units_i  (size_units_i),
    .source_node_i (source_node_i),
    .dest_node_i   (dest_node_i),
    .time_now_i    (time_now_i),
    .limit_i       (limit_q),
    .done_o        (done)
  );

  assign cfg_ready_o = 1'b1;

  always_comb begin
    offered_d = offered_q;
    served_d  = served_q;
    dropped_d = dropped_q;
    wsum_d    = wsum_q;
    status_d  = STAT_DONE;
    head_d    = '0;
    wait_d    = '0;
    case (done.outcome)
      OUT_ENQ_OK: begin
        offered_d = offered_q + 32'd1;
      end
      OUT_ENQ_FULL: begin
        offered_d = offered_q + 32'd1;
        dropped_d = dropped_q + 32'd1;
        status_d  = STAT_FULL;
      end
      OUT_DEQ_OK: begin
        served_d = served_q + 32'd1;
        wsum_d   = wsum_q + 48'(done.wait_ticks);
        head_d   = done.head;
        wait_d   = done.wait_ticks;
      end
      OUT_PEEK_OK: begin
        head_d = done.head;
      end
      OUT_EMPTY: begin
        status_d = STAT_EMPTY;
      end
      default: begin
        offered_d = '0;
        served_d  = '0;
        dropped_d = '0;
        wsum_d    = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= CNT_W'(QUEUE_DEPTH);
      done_q    <= 1'b0;
      offered_q <= '0;
      served_q  <= '0;
      dropped_q <= '0;
      wsum_q    <= '0;
      occ_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      done_q <= done.fire;
      if (done.fire) begin
        offered_q <= offered_d;
        served_q  <= served_d;
        dropped_q <= dropped_d;
        wsum_q    <= wsum_d;
        occ_q     <= done.count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done.fire) begin
      status_q <= status_d;
      head_q   <= head_d;
      wait_q   <= wait_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign out_id_o        = head_q.id;
  assign out_priority_o  = head_q.pri;
  assign out_size_o      = head_q.size;
  assign out_source_o    = head_q.src;
  assign out_dest_o      = head_q.dst;
  assign wait_ticks_o    = wait_q;
  assign occupancy_o     = occ_q;
  assign offered_count_o = offered_q;
  assign served_count_o  = served_q;
  assign dropped_count_o = dropped_q;
  assign wait_total_o    = wsum_q;

endmodule

`default_nettype wire
